// ===== rtl/gfcc_pkg.sv =====
// Package with shared types, constants and helpers for the canvas compositor.
`default_nettype none
package gfcc_pkg;
	localparam int MaxDim = 256;
	localparam int CanvasDepth = 65536;
	localparam int AddrW = $clog2(CanvasDepth);
	localparam int DimW = $clog2(MaxDim) + 1;

	localparam logic [2:0] FUNC_START = 3'd0;
	localparam logic [2:0] FUNC_PIXEL = 3'd1;
	localparam logic [2:0] FUNC_END   = 3'd2;
	localparam logic [2:0] FUNC_READ  = 3'd3;
	localparam logic [2:0] FUNC_CLEAR = 3'd4;

	localparam logic [2:0] DISP_CLEAR   = 3'd2;
	localparam logic [2:0] DISP_RESTORE = 3'd3;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_TRANS = 2'd1;
	localparam logic [1:0] ST_CLIP  = 2'd2;
	localparam logic [1:0] ST_BAD   = 2'd3;

	localparam logic [0:0] REG_WIDTH  = 1'd0;
	localparam logic [0:0] REG_HEIGHT = 1'd1;

	typedef struct packed {
		logic [2:0]  func;
		logic [15:0] frame_left;
		logic [15:0] frame_top;
		logic [15:0] frame_width;
		logic [15:0] frame_height;
		logic [2:0]  disposal;
		logic [15:0] raw_delay;
		logic [31:0] pixel_rgba;
		logic [15:0] read_index;
	} in_item_t;

	typedef struct packed {
		logic [31:0] rgba_out;
		logic [19:0] delay_ms;
		logic [1:0]  status;
	} out_item_t;

	// Walk kinds the controller asks the datapath to run.
	typedef enum logic [1:0] {
		WALK_SAVE    = 2'd0,
		WALK_RESTORE = 2'd1,
		WALK_REGION  = 2'd2,
		WALK_WIPE    = 2'd3
	} walk_t;

	typedef struct packed {
		logic  take;      // accept the held item in the datapath
		logic  walk_go;   // start a walk
		walk_t walk_kind;
		logic  walk_step; // advance the walk one entry
		logic  finish;    // emit the held result
	} dp_cmd_t;

	typedef struct packed {
		logic  needs_walk;
		walk_t walk_kind;
		logic  walk_last;
	} dp_stat_t;

	function automatic logic [DimW-1:0] eff_dim(input logic [8:0] v);
		if (v == 9'd0) return DimW'(1);
		if ({23'd0, v} > MaxDim) return DimW'(MaxDim);
		return DimW'(v);
	endfunction
endpackage
`default_nettype wire

// ===== rtl/gfcc_ctrl.sv =====
// Controller state machine of the canvas compositor.
`default_nettype none
module gfcc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	output gfcc_pkg::dp_cmd_t      cmd,
	input  wire gfcc_pkg::dp_stat_t stat
);
	import gfcc_pkg::*;

	typedef enum logic [4:0] {
		S_INIT = 5'b00001,
		S_IDLE = 5'b00010,
		S_DEC  = 5'b00100,
		S_WALK = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.walk_kind = stat.walk_kind;
		unique case (state_q)
			S_INIT: begin
				cmd.walk_kind = WALK_WIPE;
				cmd.walk_step = 1'b1;
				if (stat.walk_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.take = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				// The datapath decodes the held transaction in this cycle.
				state_d = S_DONE;
			end
			S_DONE: begin
				if (stat.needs_walk) begin
					cmd.walk_go = 1'b1;
					state_d = S_WALK;
				end else begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
				if (stat.walk_last) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_INIT;
		else state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);

	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> state_q == S_IDLE) else $error("take outside idle");
	a_take_dec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> state_q == S_DEC) else $error("take not followed by decode");
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> state_q == S_IDLE) else $error("finish not to idle");
endmodule
`default_nettype wire

// ===== rtl/gfcc_dp.sv =====
// Datapath of the canvas compositor: stores, frame registers and walks.
`default_nettype none
module gfcc_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire gfcc_pkg::in_item_t   item,
	input  wire logic [8:0]           width_reg,
	input  wire logic [8:0]           height_reg,
	input  wire gfcc_pkg::dp_cmd_t    cmd,
	output gfcc_pkg::dp_stat_t        stat,
	output logic                      result_valid,
	output gfcc_pkg::out_item_t       result
);
	import gfcc_pkg::*;

	logic [31:0] canvas_mem [CanvasDepth];
	logic [31:0] saved_mem [CanvasDepth];

	in_item_t    it_q;
	logic [DimW-1:0] w_q, h_q;
	logic [15:0] cur_left_q, cur_top_q, cur_fw_q, cur_fh_q, col_q, row_q;
	logic [2:0]  cur_disp_q;
	logic        open_q;
	logic [1:0]  status_q;
	logic [19:0] delay_q;
	logic        needs_walk_q;
	walk_t       kind_q;
	logic        take_d_q;

	// Walk counters; region walks step x in its own counter.
	logic [AddrW:0] waddr_q;
	logic [16:0] wx_q, wy_q, xe_q, ye_q;
	logic [AddrW-1:0] cnt_idx;
	logic [31:0] saved_rd_q, canvas_rd_q;
	logic        copy_pend_q, restore_pend_q;
	logic [AddrW-1:0] copy_addr_q;
	logic        walk_done;

	// Pixel address terms.
	logic [16:0] px_x, px_y;
	logic [33:0] px_addr;
	logic [33:0] reg_addr;
	logic [33:0] wh;
	logic [19:0] raw10;
	logic [DimW-1:0] w_e, h_e;

	assign w_e = eff_dim(width_reg);
	assign h_e = eff_dim(height_reg);
	assign px_x = {1'b0, cur_left_q} + {1'b0, col_q};
	assign px_y = {1'b0, cur_top_q} + {1'b0, row_q};
	assign px_addr = 34'(px_y) * 34'(w_q) + 34'(px_x);
	assign reg_addr = 34'(wy_q) * 34'(w_q) + 34'(wx_q);
	assign wh = 34'(w_q) * 34'(h_q);
	assign raw10 = 20'(it_q.raw_delay) * 20'd10;
	assign cnt_idx = waddr_q[AddrW-1:0];

	always_comb begin
		walk_done = 1'b0;
		unique case (kind_q)
			WALK_REGION: walk_done = (wy_q >= ye_q) || (xe_q <= {1'b0, cur_left_q});
			default: walk_done = waddr_q[AddrW];
		endcase
	end

	assign stat.needs_walk = needs_walk_q;
	assign stat.walk_kind = kind_q;
	assign stat.walk_last = walk_done;

	// Item decode runs in the cycle after take, once it_q holds the item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) take_d_q <= 1'b0;
		else take_d_q <= cmd.take;
	end

	always_ff @(posedge clk) begin
		if (cmd.take) it_q <= item;
	end

	// Control and frame registers; the frame state updates on the decode cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_left_q <= '0; cur_top_q <= '0; cur_fw_q <= '0; cur_fh_q <= '0;
			col_q <= '0; row_q <= '0; cur_disp_q <= '0; open_q <= 1'b0;
			needs_walk_q <= 1'b1; kind_q <= WALK_WIPE; waddr_q <= '0;
			wx_q <= '0; wy_q <= '0; xe_q <= '0; ye_q <= '0;
			result_valid <= 1'b0; status_q <= ST_DONE; delay_q <= '0;
			w_q <= '0; h_q <= '0;
		end else begin
			result_valid <= cmd.finish;
			if (cmd.take) begin
				w_q <= w_e;
				h_q <= h_e;
				needs_walk_q <= 1'b0;
				status_q <= ST_DONE;
				delay_q <= '0;
			end
			if (cmd.walk_go) begin
				waddr_q <= '0;
				wy_q <= {1'b0, cur_top_q};
				wx_q <= {1'b0, cur_left_q};
			end else if (cmd.walk_step) begin
				if (kind_q == WALK_REGION) begin
					if (wx_q + 17'd1 >= xe_q) begin
						wx_q <= {1'b0, cur_left_q};
						wy_q <= wy_q + 17'd1;
					end else wx_q <= wx_q + 17'd1;
				end else waddr_q <= waddr_q + 1'b1;
				if (walk_done) begin
					needs_walk_q <= 1'b0;
					if (kind_q == WALK_REGION || kind_q == WALK_RESTORE) begin
						open_q <= 1'b0; col_q <= '0; row_q <= '0;
					end
				end
			end
			if (take_d_q) begin
				case (it_q.func)
					FUNC_START: begin
						if (open_q || it_q.frame_width == 16'd0
							|| it_q.frame_height == 16'd0)
							status_q <= ST_BAD;
						else begin
							delay_q <= (raw10 < 20'd20) ? 20'd100 : raw10;
							cur_left_q <= it_q.frame_left; cur_top_q <= it_q.frame_top;
							cur_fw_q <= it_q.frame_width; cur_fh_q <= it_q.frame_height;
							cur_disp_q <= it_q.disposal; col_q <= '0; row_q <= '0;
							open_q <= 1'b1;
							if (it_q.disposal == DISP_RESTORE) begin
								needs_walk_q <= 1'b1; kind_q <= WALK_SAVE;
							end
						end
					end
					FUNC_PIXEL: begin
						if (!open_q || row_q >= cur_fh_q) status_q <= ST_BAD;
						else begin
							if (px_x >= 17'(w_q) || px_y >= 17'(h_q)
								|| px_addr >= CanvasDepth)
								status_q <= ST_CLIP;
							else if (it_q.pixel_rgba[31:24] == 8'd0) status_q <= ST_TRANS;
							if (col_q + 16'd1 >= cur_fw_q) begin
								col_q <= '0; row_q <= row_q + 16'd1;
							end else col_q <= col_q + 16'd1;
						end
					end
					FUNC_END: begin
						if (!open_q) status_q <= ST_BAD;
						else if (cur_disp_q == DISP_CLEAR) begin
							needs_walk_q <= 1'b1; kind_q <= WALK_REGION;
							xe_q <= ({1'b0, cur_left_q} + {1'b0, cur_fw_q} > 17'(w_q))
								? 17'(w_q) : {1'b0, cur_left_q} + {1'b0, cur_fw_q};
							ye_q <= ({1'b0, cur_top_q} + {1'b0, cur_fh_q} > 17'(h_q))
								? 17'(h_q) : {1'b0, cur_top_q} + {1'b0, cur_fh_q};
						end else if (cur_disp_q == DISP_RESTORE) begin
							needs_walk_q <= 1'b1; kind_q <= WALK_RESTORE;
						end else begin
							open_q <= 1'b0; col_q <= '0; row_q <= '0;
						end
					end
					FUNC_READ: begin
						if (34'(it_q.read_index) >= wh) status_q <= ST_BAD;
					end
					FUNC_CLEAR: begin
						needs_walk_q <= 1'b1; kind_q <= WALK_WIPE;
						cur_left_q <= '0; cur_top_q <= '0; cur_fw_q <= '0; cur_fh_q <= '0;
						cur_disp_q <= '0; col_q <= '0; row_q <= '0; open_q <= 1'b0;
					end
					default: status_q <= ST_BAD;
				endcase
			end
		end
	end

	// Canvas memory port: pixel write, walk writes, and registered read.
	logic        pix_we;
	logic        region_we;
	assign pix_we = take_d_q && it_q.func == FUNC_PIXEL && open_q && row_q < cur_fh_q
		&& px_x < 17'(w_q) && px_y < 17'(h_q) && px_addr < CanvasDepth
		&& it_q.pixel_rgba[31:24] != 8'd0;
	assign region_we = cmd.walk_step && kind_q == WALK_REGION && !walk_done
		&& reg_addr < CanvasDepth;

	always_ff @(posedge clk) begin
		canvas_rd_q <= canvas_mem[cmd.walk_step ? cnt_idx : it_q.read_index];
		saved_rd_q <= saved_mem[cnt_idx];
		if (pix_we) canvas_mem[px_addr[AddrW-1:0]] <= it_q.pixel_rgba;
		else if (region_we) canvas_mem[reg_addr[AddrW-1:0]] <= '0;
		else if (cmd.walk_step && kind_q == WALK_WIPE && !walk_done)
			canvas_mem[cnt_idx] <= '0;
		else if (restore_pend_q) canvas_mem[copy_addr_q] <= saved_rd_q;
		if (cmd.walk_step && kind_q == WALK_WIPE && !walk_done) saved_mem[cnt_idx] <= '0;
		else if (copy_pend_q) saved_mem[copy_addr_q] <= canvas_rd_q;
	end

	// Copies run in the cycle after the read; the last entry lands while finishing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_pend_q <= 1'b0; restore_pend_q <= 1'b0; copy_addr_q <= '0;
		end else begin
			copy_pend_q <= cmd.walk_step && kind_q == WALK_SAVE && !walk_done;
			restore_pend_q <= cmd.walk_step && kind_q == WALK_RESTORE && !walk_done;
			copy_addr_q <= cnt_idx;
		end
	end

	// Read data lands in the done cycle and is registered at the finish edge.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result.rgba_out <= (it_q.func == FUNC_READ && status_q == ST_DONE)
				? canvas_rd_q : '0;
			result.delay_ms <= delay_q;
			result.status <= status_q;
		end
	end

	a_pix_open: assert property (@(posedge clk) disable iff (!arst_n)
		pix_we |-> open_q) else $error("pixel write with no open frame");
	a_one_wr: assert property (@(posedge clk) disable iff (!arst_n)
		!(pix_we && (region_we || restore_pend_q))) else $error("write collision");
	a_res: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(cmd.finish)) else $error("stray result");
endmodule
`default_nettype wire

// ===== rtl/gif_frame_canvas_compositor_core.sv =====
// Top level of the GIF frame canvas compositor.
`default_nettype none
// Usage: drive cmd_in with a transaction and raise start while busy is low;
// the transaction is taken at that edge. One result appears on result for
// exactly one cycle, marked by done; the receiver cannot stall it.
// Pixel, read, plain end and bad transactions pass through the decode and
// done states with no walk; busy stays high until the result is out, so the
// block takes no new transaction before the last one finishes. A frame start
// with disposal 3 copies the whole canvas; a frame end with disposal 3
// copies it back; a frame end with disposal 2 clears the clipped rectangle,
// one pixel a cycle; a clear wipes both stores. These walks share the
// single canvas port.
// After reset the block runs a clearing pass with busy high; configuration
// writes are taken at any time through cfg_we, cfg_index and cfg_data, and
// take effect on the next transaction.
// Reset values of the canvas size are 256 by 256.
module gif_frame_canvas_compositor_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire gfcc_pkg::in_item_t   cmd_in,
	output logic                      done,
	output gfcc_pkg::out_item_t       result,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [8:0]           cfg_data
);
	import gfcc_pkg::*;

	logic [8:0] width_q, height_q;
	dp_cmd_t    cmd;
	dp_stat_t   stat;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 9'd256;
			height_q <= 9'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH: width_q <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	gfcc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd), .stat(stat)
	);

	gfcc_dp u_dp (
		.clk(clk), .arst_n(arst_n), .item(cmd_in), .width_reg(width_q),
		.height_reg(height_q), .cmd(cmd), .stat(stat), .result_valid(done),
		.result(result)
	);

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("transaction not taken");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_index == REG_WIDTH) |=> width_q == $past(cfg_data))
		else $error("width write lost");
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the GIF frame canvas compositor core.
`timescale 1ns / 100ps
module tb;
	import gfcc_pkg::*;

	localparam int LimitCycles = 4000000;

	// Sender idling modes, one per random phase.
	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct {
		in_item_t  cmd;
		bit        typed;
		out_item_t want;
	} dir_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	logic      busy;
	in_item_t  cmd_in = '0;
	logic      done;
	out_item_t result;
	logic      cfg_we = 1'b0;
	logic      cfg_index = 1'b0;
	logic [8:0] cfg_data = '0;

	// Shadow of the block's state, kept in step with every accepted transaction.
	logic [31:0] canvas_mem [CanvasDepth];
	logic [31:0] saved_mem [CanvasDepth];
	logic [8:0]  reg_w, reg_h;
	int unsigned frm_left, frm_top, frm_w, frm_h, frm_col, frm_row;
	logic [2:0]  frm_disp;
	bit          frm_open;

	out_item_t   pending_results[$];
	dir_row_t    directed [$];
	int          fail_count = 0;
	int          cycle_count = 0;
	int          sender_idle_pct = 0;
	int          restore_budget = 2;
	int          clear_budget = 2;

	gif_frame_canvas_compositor_core u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd_in(cmd_in),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Watchdog: a stuck handshake or a missing result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LimitCycles) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Results are taken at the edge that ends their single valid cycle.
	always @(posedge clk) begin
		if (done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected transaction result %h", $time, result);
				fail_count++;
			end else begin
				out_item_t want;
				want = pending_results[0];
				pending_results.delete(0);
				if (result.rgba_out !== want.rgba_out)
					$display("%0t: rgba_out expected %h actual %h", $time,
						want.rgba_out, result.rgba_out);
				if (result.delay_ms !== want.delay_ms)
					$display("%0t: delay_ms expected %0d actual %0d", $time,
						want.delay_ms, result.delay_ms);
				if (result.status !== want.status)
					$display("%0t: status expected %0d actual %0d", $time,
						want.status, result.status);
				if (result !== want)
					fail_count++;
			end
		end
	end

	function automatic int unsigned dim_of(logic [8:0] v);
		if (v == 9'd0)
			return 1;
		if (v > MaxDim)
			return MaxDim;
		return v;
	endfunction

	function automatic void wipe_frame();
		frm_left = 0; frm_top = 0; frm_w = 0; frm_h = 0;
		frm_disp = '0; frm_col = 0; frm_row = 0; frm_open = 0;
	endfunction

	// Computes the result of one transaction and advances the shadow state.
	function automatic out_item_t composite(in_item_t c);
		out_item_t   r;
		int unsigned w, h, x, y, a, xe, ye, dly;
		r = '0;
		w = dim_of(reg_w);
		h = dim_of(reg_h);
		case (c.func)
			FUNC_START: begin
				if (frm_open || c.frame_width == 0 || c.frame_height == 0) begin
					r.status = ST_BAD;
				end else begin
					dly = c.raw_delay * 10;
					r.delay_ms = (dly < 20) ? 20'd100 : dly[19:0];
					frm_left = c.frame_left;
					frm_top = c.frame_top;
					frm_w = c.frame_width;
					frm_h = c.frame_height;
					frm_disp = c.disposal;
					frm_col = 0;
					frm_row = 0;
					frm_open = 1;
					if (frm_disp == DISP_RESTORE)
						saved_mem = canvas_mem;
				end
			end
			FUNC_PIXEL: begin
				if (!frm_open || frm_row >= frm_h) begin
					r.status = ST_BAD;
				end else begin
					x = frm_left + frm_col;
					y = frm_top + frm_row;
					a = y * w + x;
					if (x >= w || y >= h || a >= CanvasDepth)
						r.status = ST_CLIP;
					else if (c.pixel_rgba[31:24] == 8'd0)
						r.status = ST_TRANS;
					else
						canvas_mem[a] = c.pixel_rgba;
					frm_col++;
					if (frm_col >= frm_w) begin
						frm_col = 0;
						frm_row++;
					end
				end
			end
			FUNC_END: begin
				if (!frm_open) begin
					r.status = ST_BAD;
				end else begin
					if (frm_disp == DISP_CLEAR) begin
						xe = (frm_left + frm_w > w) ? w : frm_left + frm_w;
						ye = (frm_top + frm_h > h) ? h : frm_top + frm_h;
						for (y = frm_top; y < ye; y++)
							for (x = frm_left; x < xe; x++)
								if (y * w + x < CanvasDepth)
									canvas_mem[y * w + x] = '0;
					end else if (frm_disp == DISP_RESTORE) begin
						canvas_mem = saved_mem;
					end
					frm_open = 0;
					frm_col = 0;
					frm_row = 0;
				end
			end
			FUNC_READ: begin
				if (c.read_index >= w * h)
					r.status = ST_BAD;
				else
					r.rgba_out = canvas_mem[c.read_index];
			end
			FUNC_CLEAR: begin
				foreach (canvas_mem[i]) begin
					canvas_mem[i] = '0;
					saved_mem[i] = '0;
				end
				wipe_frame();
			end
			default: r.status = ST_BAD;
		endcase
		return r;
	endfunction

	function automatic in_item_t mk(int unsigned f, int unsigned l, int unsigned t,
			int unsigned fw, int unsigned fh, int unsigned d, int unsigned rd,
			int unsigned px, int unsigned ri);
		in_item_t c;
		c.func = 3'(f); c.frame_left = 16'(l); c.frame_top = 16'(t);
		c.frame_width = 16'(fw); c.frame_height = 16'(fh); c.disposal = 3'(d);
		c.raw_delay = 16'(rd); c.pixel_rgba = px; c.read_index = 16'(ri);
		return c;
	endfunction

	function automatic void append_row(in_item_t c, bit typed, out_item_t want);
		dir_row_t row;
		row.cmd = c;
		row.typed = typed;
		row.want = want;
		directed.insert(directed.size(), row);
	endfunction

	// Drives one transaction and holds it until the block takes it. Called
	// right after a rising edge; leaves start high when no gap follows.
	task automatic issue(in_item_t c, bit typed, out_item_t want);
		out_item_t predicted;
		int gap;
		start <= 1'b1;
		cmd_in <= c;
		do
			@(posedge clk);
		while (busy);
		predicted = composite(c);
		pending_results.insert(pending_results.size(), typed ? want : predicted);
		gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send(in_item_t c);
		issue(c, 1'b0, '0);
	endtask

	// Configuration only changes with nothing in flight.
	task automatic set_canvas(logic [8:0] w, logic [8:0] h);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= REG_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_w = w;
		reg_h = h;
		@(posedge clk);
	endtask

	function automatic logic [2:0] pick_disposal(bit allow_clear);
		logic [2:0] d;
		d = 3'($urandom_range(7));
		if (d == DISP_RESTORE || (d == DISP_CLEAR && !allow_clear))
			d ^= 3'b100;
		return d;
	endfunction

	function automatic logic [31:0] pick_pixel();
		logic [31:0] px;
		px = $urandom;
		if ($urandom_range(4) == 0)
			px[31:24] = 8'd0;
		return px;
	endfunction

	function automatic logic [15:0] pick_read();
		int unsigned n;
		n = dim_of(reg_w) * dim_of(reg_h);
		if ($urandom_range(1) == 0)
			return 16'($urandom_range(n - 1));
		return 16'($urandom);
	endfunction

	// A well-formed frame: start, its pixels in raster order with reads mixed
	// in, then the end. Sometimes short or with one pixel too many.
	task automatic frame_sequence();
		logic [15:0] l, t, fw, fh, rd;
		logic [2:0]  d;
		int n;
		bit big;
		big = ($urandom_range(19) == 0);
		fw = big ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 8));
		fh = big ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 8));
		if ($urandom_range(4) == 0) begin
			l = 16'($urandom);
			t = 16'($urandom);
		end else begin
			l = 16'($urandom_range(dim_of(reg_w) - 1));
			t = 16'($urandom_range(dim_of(reg_h) - 1));
		end
		d = pick_disposal(!big);
		if (restore_budget > 0 && $urandom_range(199) == 0) begin
			d = DISP_RESTORE;
			restore_budget--;
		end
		rd = ($urandom_range(3) == 0) ? 16'($urandom_range(3)) : 16'($urandom);
		send(mk(FUNC_START, l, t, fw, fh, d, rd, $urandom, $urandom));
		n = big ? $urandom_range(1, 12) : fw * fh;
		case ($urandom_range(9))
			0: n = $urandom_range(n);
			1: n = n + 1;
			default: ;
		endcase
		repeat (n) begin
			if ($urandom_range(9) == 0)
				send(mk(FUNC_READ, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, pick_read()));
			send(mk(FUNC_PIXEL, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, pick_pixel(), $urandom));
		end
		send(mk(FUNC_END, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom));
	endtask

	// Noise: any func, any field. Starts stay cheap and clears are rationed,
	// since both walk the whole store.
	task automatic noise_item();
		in_item_t c;
		c = mk($urandom_range(7), $urandom, $urandom, $urandom, $urandom,
			pick_disposal(1'b0), $urandom, pick_pixel(), pick_read());
		if (c.func == FUNC_START && $urandom_range(3) == 0)
			c.frame_width = 16'd0;
		if (c.func == FUNC_CLEAR) begin
			if (clear_budget > 0)
				clear_budget--;
			else
				c.func = FUNC_READ;
		end
		send(c);
	endtask

	task automatic random_phase(idle_mode_t mode, int items);
		case (mode)
			IDLE_SEND: sender_idle_pct = 63;
			IDLE_BOTH: sender_idle_pct = 11;
			default: sender_idle_pct = 0;
		endcase
		repeat (items / 20) begin
			if ($urandom_range(3) != 0)
				frame_sequence();
			else
				repeat (4) noise_item();
		end
		sender_idle_pct = 0;
	endtask

	initial begin
		foreach (canvas_mem[i]) begin
			canvas_mem[i] = '0;
			saved_mem[i] = '0;
		end
		reg_w = 9'd256;
		reg_h = 9'd256;
		wipe_frame();

		// Reads after reset, both ends of the index range.
		append_row(mk(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 16'd0), 1, '{0, 0, ST_DONE});
		append_row(mk(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF), 1,
			'{0, 0, ST_DONE});
		// Unknown funcs, and pixel or end with no open frame.
		append_row(mk(3'd5, 0, 0, 1, 1, 0, 0, 0, 0), 1, '{0, 0, ST_BAD});
		append_row(mk(3'd6, 0, 0, 1, 1, 0, 0, 0, 0), 1, '{0, 0, ST_BAD});
		append_row(mk(3'd7, 0, 0, 1, 1, 0, 0, 0, 0), 1, '{0, 0, ST_BAD});
		append_row(mk(FUNC_PIXEL, 0, 0, 0, 0, 0, 0, 32'hFFFFFFFF, 0), 1,
			'{0, 0, ST_BAD});
		append_row(mk(FUNC_END, 0, 0, 0, 0, 0, 0, 0, 0), 1, '{0, 0, ST_BAD});
		// Zero-sized frames are refused.
		append_row(mk(FUNC_START, 0, 0, 0, 2, 0, 50, 0, 0), 1, '{0, 0, ST_BAD});
		append_row(mk(FUNC_START, 0, 0, 2, 0, 0, 50, 0, 0), 1, '{0, 0, ST_BAD});
		// A 2x2 frame with region clear; zero delay becomes 100 ms.
		append_row(mk(FUNC_START, 0, 0, 2, 2, DISP_CLEAR, 0, 0, 0), 1,
			'{0, 100, ST_DONE});
		append_row(mk(FUNC_START, 0, 0, 2, 2, 0, 9, 0, 0), 1, '{0, 0, ST_BAD});
		append_row(mk(FUNC_PIXEL, 0, 0, 0, 0, 0, 0, 32'hFFFFFFFF, 0), 1,
			'{0, 0, ST_DONE});
		append_row(mk(FUNC_PIXEL, 0, 0, 0, 0, 0, 0, 32'h00ABCDEF, 0), 1,
			'{0, 0, ST_TRANS});
		append_row(mk(FUNC_PIXEL, 0, 0, 0, 0, 0, 0, 32'h01000001, 0), 1,
			'{0, 0, ST_DONE});
		append_row(mk(FUNC_PIXEL, 0, 0, 0, 0, 0, 0, 32'h80123456, 0), 1,
			'{0, 0, ST_DONE});
		append_row(mk(FUNC_PIXEL, 0, 0, 0, 0, 0, 0, 32'h80123456, 0), 1,
			'{0, 0, ST_BAD});
		append_row(mk(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 16'd256), 0, '0);
		append_row(mk(FUNC_END, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
		append_row(mk(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 16'd0), 0, '0);
		// Largest frame, fully off the canvas; largest delay.
		append_row(mk(FUNC_START, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7,
			16'hFFFF, 0, 0), 1, '{0, 20'd655350, ST_DONE});
		append_row(mk(FUNC_PIXEL, 0, 0, 0, 0, 0, 0, 32'hFF00FF00, 0), 1,
			'{0, 0, ST_CLIP});
		append_row(mk(FUNC_END, 0, 0, 0, 0, 0, 0, 0, 0), 1, '{0, 0, ST_DONE});
		// Restore-previous frame in the last canvas corner.
		append_row(mk(FUNC_START, 16'd255, 16'd255, 1, 1, DISP_RESTORE, 1, 0, 0),
			1, '{0, 100, ST_DONE});
		append_row(mk(FUNC_PIXEL, 0, 0, 0, 0, 0, 0, 32'h12345678, 0), 0, '0);
		append_row(mk(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF), 0, '0);
		append_row(mk(FUNC_END, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
		append_row(mk(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF), 0, '0);
		// Keep frame, then a clear wipes it.
		append_row(mk(FUNC_START, 16'd10, 0, 1, 1, 3'd1, 2, 0, 0), 1,
			'{0, 20, ST_DONE});
		append_row(mk(FUNC_PIXEL, 0, 0, 0, 0, 0, 0, 32'hA5A5A5A5, 0), 0, '0);
		append_row(mk(FUNC_END, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
		append_row(mk(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 16'd10), 0, '0);
		append_row(mk(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1, '{0, 0, ST_DONE});
		append_row(mk(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 16'd10), 1, '{0, 0, ST_DONE});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			issue(directed[i].cmd, directed[i].typed, directed[i].want);

		// Random phases, each with its own canvas size and idling pattern;
		// the extremes of the size registers come first.
		set_canvas(9'd0, 9'd511);
		random_phase(IDLE_NONE, 300);
		set_canvas(9'd37, 9'd300);
		random_phase(IDLE_SEND, 300);
		set_canvas(9'd256, 9'd1);
		random_phase(IDLE_RECV, 200);
		set_canvas(9'($urandom_range(1, 511)), 9'($urandom_range(1, 511)));
		random_phase(IDLE_BOTH, 200);
		set_canvas(9'd511, 9'd256);
		random_phase(IDLE_BOTH, 200);

		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/gfcc_pkg.sv
rtl/gfcc_ctrl.sv
rtl/gfcc_dp.sv
rtl/gif_frame_canvas_compositor_core.sv
tb/sv/tb.sv
